FILE: rtl/glyph_quad_layout_kerning_top_assert.svh
// Assertion macros shared by the glyph quad layout RTL.
`ifndef GLYPH_QUAD_LAYOUT_KERNING_TOP_ASSERT_SVH
`define GLYPH_QUAD_LAYOUT_KERNING_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// checked outside reset
`define GQLK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define GQLK_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GQLK_ASSERT(lbl, prop, msg)
`define GQLK_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: rtl/gqlk_pkg.sv
// Shared types, codes and helpers for the glyph quad layout engine.
`default_nettype none
package gqlk_pkg;

  // default table sizes
  localparam int GLYPH_ENTRIES_DEF = 256;
  localparam int KERN_ROWS_DEF     = 128;
  localparam int KERN_COLS_DEF     = 128;

  // output queue depth (power of two)
  localparam int OUT_DEPTH = 8;

  // config bus address width: seven 32-bit registers
  localparam int PADDR_W = 5;

  // register reset values
  localparam logic [15:0] SCALE_RST          = 16'd256;
  localparam logic [15:0] GLYPH_FIRST_RST    = 16'd32;
  localparam logic [15:0] GLYPH_LIMIT_RST    = 16'd128;
  localparam logic [15:0] KERN_FIRST_RST     = 16'd32;
  localparam logic [15:0] KERN_LIMIT_RST     = 16'd128;
  localparam logic [15:0] KERN_COL_FIRST_RST = 16'd32;
  localparam logic [15:0] KERN_COL_LIMIT_RST = 16'd128;

  typedef enum logic [1:0] {
    CMD_START      = 2'd0,
    CMD_CHAR       = 2'd1,
    CMD_LOAD_GLYPH = 2'd2,
    CMD_LOAD_KERN  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SCALE          = 3'd0,
    REG_GLYPH_FIRST    = 3'd1,
    REG_GLYPH_LIMIT    = 3'd2,
    REG_KERN_FIRST     = 3'd3,
    REG_KERN_LIMIT     = 3'd4,
    REG_KERN_COL_FIRST = 3'd5,
    REG_KERN_COL_LIMIT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] scale;
    logic [15:0] glyph_first;
    logic [15:0] glyph_limit;
    logic [15:0] kern_first;
    logic [15:0] kern_limit;
    logic [15:0] kern_col_first;
    logic [15:0] kern_col_limit;
  } cfg_t;

  // one glyph table entry
  typedef struct packed {
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic [9:0]         gw;
    logic [9:0]         gh;
    logic signed [10:0] adv;
    logic [15:0]        u0;
    logic [15:0]        v0;
    logic [15:0]        u1;
    logic [15:0]        v1;
  } glyph_rec_t;

  // control word handed from the front end to the math pipe
  typedef struct packed {
    logic               valid;
    logic               is_start;
    logic               kern_use;
    logic signed [31:0] xv;
    logic signed [31:0] yv;
    logic [13:0]        quad_number;
  } front_word_t;

  // one finished quad
  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic signed [31:0] top;
    logic signed [31:0] bottom;
    logic [15:0]        u0;
    logic [15:0]        v0;
    logic [15:0]        u1;
    logic [15:0]        v1;
    logic [13:0]        quad_number;
  } quad_t;

  localparam logic signed [50:0] SAT_HI = 51'sd2147483647;
  localparam logic signed [50:0] SAT_LO = -51'sd2147483648;

  // clamp a wide signed sum to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/gqlk_regs.sv
// Configuration register file on the APB-style port.
`default_nettype none
module gqlk_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gqlk_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output gqlk_pkg::cfg_t                     cfg
);
  import gqlk_pkg::*;

  logic     wr_en;
  reg_idx_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_idx_t'(paddr[PADDR_W-1:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale          <= SCALE_RST;
      cfg.glyph_first    <= GLYPH_FIRST_RST;
      cfg.glyph_limit    <= GLYPH_LIMIT_RST;
      cfg.kern_first     <= KERN_FIRST_RST;
      cfg.kern_limit     <= KERN_LIMIT_RST;
      cfg.kern_col_first <= KERN_COL_FIRST_RST;
      cfg.kern_col_limit <= KERN_COL_LIMIT_RST;
    end else if (wr_en) begin
      case (sel)
        REG_SCALE:          cfg.scale          <= pwdata[15:0];
        REG_GLYPH_FIRST:    cfg.glyph_first    <= pwdata[15:0];
        REG_GLYPH_LIMIT:    cfg.glyph_limit    <= pwdata[15:0];
        REG_KERN_FIRST:     cfg.kern_first     <= pwdata[15:0];
        REG_KERN_LIMIT:     cfg.kern_limit     <= pwdata[15:0];
        REG_KERN_COL_FIRST: cfg.kern_col_first <= pwdata[15:0];
        REG_KERN_COL_LIMIT: cfg.kern_col_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (sel)
      REG_SCALE:          prdata = {16'd0, cfg.scale};
      REG_GLYPH_FIRST:    prdata = {16'd0, cfg.glyph_first};
      REG_GLYPH_LIMIT:    prdata = {16'd0, cfg.glyph_limit};
      REG_KERN_FIRST:     prdata = {16'd0, cfg.kern_first};
      REG_KERN_LIMIT:     prdata = {16'd0, cfg.kern_limit};
      REG_KERN_COL_FIRST: prdata = {16'd0, cfg.kern_col_first};
      REG_KERN_COL_LIMIT: prdata = {16'd0, cfg.kern_col_limit};
      default:            prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/gqlk_front.sv
// Command decode, glyph and kerning memories, string-level state.
`default_nettype none
`include "glyph_quad_layout_kerning_top_assert.svh"
module gqlk_front #(
  parameter int GLYPH_ENTRIES = gqlk_pkg::GLYPH_ENTRIES_DEF,
  parameter int KERN_ROWS     = gqlk_pkg::KERN_ROWS_DEF,
  parameter int KERN_COLS     = gqlk_pkg::KERN_COLS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_acc,
  input  wire logic [1:0]           command,
  input  wire logic [15:0]          code,
  input  wire logic [15:0]          column,
  input  wire logic signed [31:0]   x_value,
  input  wire logic signed [31:0]   y_value,
  input  wire logic [9:0]           box_width,
  input  wire logic [9:0]           box_height,
  input  wire logic signed [10:0]   advance,
  input  wire logic [15:0]          tex_u0,
  input  wire logic [15:0]          tex_v0,
  input  wire logic [15:0]          tex_u1,
  input  wire logic [15:0]          tex_v1,
  input  wire gqlk_pkg::cfg_t       cfg,
  output gqlk_pkg::front_word_t     s1,
  output gqlk_pkg::glyph_rec_t      glyph,
  output logic signed [7:0]         kern,
  output logic                      reserve
);
  import gqlk_pkg::*;

  localparam int GAW        = $clog2(GLYPH_ENTRIES);
  localparam int RW         = $clog2(KERN_ROWS);
  localparam int CW         = $clog2(KERN_COLS);
  localparam int KERN_DEPTH = KERN_ROWS * KERN_COLS;
  localparam int KAW        = $clog2(KERN_DEPTH);

  cmd_t cmd;

  // string state, tracked at accept time
  logic [15:0] prev_code;
  logic        prev_valid;
  logic [13:0] quad_count;

  logic [GLYPH_ENTRIES-1:0] glyph_loaded;
  logic [KERN_ROWS-1:0]     kern_row_loaded;

  glyph_rec_t  glyph_mem [GLYPH_ENTRIES];
  logic [7:0]  kern_mem  [KERN_DEPTH];

  logic [15:0]    g_off;
  logic           g_in_table;
  logic [GAW-1:0] g_idx;
  logic           char_ok;
  logic           glyph_wr;
  glyph_rec_t     new_rec;

  logic [15:0]    row_src, col_src, r_off, c_off;
  logic           row_ok, col_ok;
  logic [RW-1:0]  k_row;
  logic [CW-1:0]  k_col;
  logic [KAW-1:0] k_addr;
  logic           kern_use;
  logic           kern_wr;

  assign cmd = cmd_t'(command);

  // glyph index and range checks
  assign g_off      = code - cfg.glyph_first;
  assign g_in_table = (code >= cfg.glyph_first) && ({1'b0, g_off} < 17'(GLYPH_ENTRIES));
  assign g_idx      = g_off[GAW-1:0];
  assign char_ok    = (cmd == CMD_CHAR) && (code < cfg.glyph_limit) && g_in_table
                      && glyph_loaded[g_idx];
  assign glyph_wr   = in_acc && (cmd == CMD_LOAD_GLYPH) && g_in_table;

  assign new_rec.gx  = x_value;
  assign new_rec.gy  = y_value;
  assign new_rec.gw  = box_width;
  assign new_rec.gh  = box_height;
  assign new_rec.adv = advance;
  assign new_rec.u0  = tex_u0;
  assign new_rec.v0  = tex_v0;
  assign new_rec.u1  = tex_u1;
  assign new_rec.v1  = tex_v1;

  // kerning address: load uses (code, column), a character uses (prev, code)
  assign row_src = (cmd == CMD_LOAD_KERN) ? code : prev_code;
  assign col_src = (cmd == CMD_LOAD_KERN) ? column : code;
  assign r_off   = row_src - cfg.kern_first;
  assign c_off   = col_src - cfg.kern_col_first;
  assign row_ok  = (row_src >= cfg.kern_first) && (row_src < cfg.kern_limit)
                   && ({1'b0, r_off} < 17'(KERN_ROWS));
  assign col_ok  = (col_src >= cfg.kern_col_first) && (col_src < cfg.kern_col_limit)
                   && ({1'b0, c_off} < 17'(KERN_COLS));
  assign k_row   = r_off[RW-1:0];
  assign k_col   = c_off[CW-1:0];
  assign k_addr  = KAW'(KAW'(k_row) * KAW'(KERN_COLS) + KAW'(k_col));

  assign kern_use = prev_valid && row_ok && kern_row_loaded[k_row] && col_ok;
  assign kern_wr  = in_acc && (cmd == CMD_LOAD_KERN) && row_ok && col_ok;

  assign reserve = in_acc && char_ok;

  // glyph table: one access per cycle
  always_ff @(posedge clk) begin
    if (glyph_wr) begin
      glyph_mem[g_idx] <= new_rec;
    end else if (in_acc && char_ok) begin
      glyph <= glyph_mem[g_idx];
    end
  end

  // kerning table: one access per cycle
  always_ff @(posedge clk) begin
    if (kern_wr) begin
      kern_mem[k_addr] <= x_value[7:0];
    end else if (in_acc && char_ok && kern_use) begin
      kern <= $signed(kern_mem[k_addr]);
    end
  end

  // valid bits and string state
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_loaded    <= '0;
      kern_row_loaded <= '0;
      prev_code       <= 16'd0;
      prev_valid      <= 1'b0;
      quad_count      <= 14'd0;
    end else if (in_acc) begin
      if (glyph_wr) begin
        glyph_loaded[g_idx] <= 1'b1;
      end
      if (kern_wr) begin
        kern_row_loaded[k_row] <= 1'b1;
      end
      if (cmd == CMD_START) begin
        prev_valid <= 1'b0;
        quad_count <= 14'd0;
      end else if (char_ok) begin
        prev_valid <= 1'b1;
        prev_code  <= code;
        quad_count <= quad_count + 14'd1;
      end
    end
  end

  // control word into the math pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= in_acc && ((cmd == CMD_START) || char_ok);
    end
    s1.is_start    <= (cmd == CMD_START);
    s1.kern_use    <= kern_use;
    s1.xv          <= x_value;
    s1.yv          <= y_value;
    s1.quad_number <= quad_count;
  end

  // a rejected character leaves the string state alone
  `GQLK_ASSERT(a_reject_keeps_state, in_acc && (cmd == CMD_CHAR) && !char_ok |=> (prev_code == $past(prev_code)) && (quad_count == $past(quad_count)), "rejected char changed string state")

endmodule
`default_nettype wire

FILE: rtl/gqlk_math.sv
// Scale products, pen update and saturating quad edges.
`default_nettype none
`include "glyph_quad_layout_kerning_top_assert.svh"
module gqlk_math (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [15:0]           scale,
  input  wire gqlk_pkg::front_word_t s1,
  input  wire gqlk_pkg::glyph_rec_t  glyph,
  input  wire logic signed [7:0]     kern,
  output logic                       push,
  output gqlk_pkg::quad_t            quad
);
  import gqlk_pkg::*;

  logic signed [16:0] sc;

  // stage 2 registers: products
  logic               s2_valid, s2_start, s2_kern_use;
  logic signed [31:0] s2_xv, s2_yv;
  logic signed [48:0] s2_px, s2_py;
  logic signed [27:0] s2_pw, s2_ph, s2_pa;
  logic signed [24:0] s2_pk;
  logic [15:0]        s2_u0, s2_v0, s2_u1, s2_v1;
  logic [13:0]        s2_qn;

  // pen state
  logic signed [31:0] pen_x, pen_y;

  // stage 3 registers: pen and offsets
  logic               s3_valid;
  logic signed [31:0] s3_pk, s3_py0;
  logic signed [48:0] s3_px, s3_py;
  logic signed [49:0] s3_dxr, s3_dyb;
  logic [15:0]        s3_u0, s3_v0, s3_u1, s3_v1;
  logic [13:0]        s3_qn;

  logic signed [50:0] kern_sum, adv_sum;
  logic signed [31:0] pk;

  assign sc = $signed({1'b0, scale});

  // stage 1: six parallel multiplies by the scale
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1.valid;
    end
    s2_start    <= s1.is_start;
    s2_kern_use <= s1.kern_use;
    s2_xv       <= s1.xv;
    s2_yv       <= s1.yv;
    s2_qn       <= s1.quad_number;
    s2_px       <= sc * glyph.gx;
    s2_py       <= sc * glyph.gy;
    s2_pw       <= sc * $signed({1'b0, glyph.gw});
    s2_ph       <= sc * $signed({1'b0, glyph.gh});
    s2_pa       <= sc * glyph.adv;
    s2_pk       <= sc * kern;
    s2_u0       <= glyph.u0;
    s2_v0       <= glyph.v0;
    s2_u1       <= glyph.u1;
    s2_v1       <= glyph.v1;
  end

  // stage 2: kerning then advance, each saturated
  assign kern_sum = 51'(pen_x) + 51'(s2_pk);
  assign pk       = s2_kern_use ? sat32(kern_sum) : pen_x;
  assign adv_sum  = 51'(pk) + 51'(s2_pa);

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x    <= 32'sd0;
      pen_y    <= 32'sd0;
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid && !s2_start;
      if (s2_valid) begin
        if (s2_start) begin
          pen_x <= s2_xv;
          pen_y <= s2_yv;
        end else begin
          pen_x <= sat32(adv_sum);
        end
      end
    end
    s3_pk  <= pk;
    s3_py0 <= pen_y;
    s3_px  <= s2_px;
    s3_py  <= s2_py;
    s3_dxr <= 50'(s2_px) + 50'(s2_pw);
    s3_dyb <= 50'(s2_py) + 50'(s2_ph);
    s3_u0  <= s2_u0;
    s3_v0  <= s2_v0;
    s3_u1  <= s2_u1;
    s3_v1  <= s2_v1;
    s3_qn  <= s2_qn;
  end

  // stage 3: left, right, top and bottom quad edges
  assign push             = s3_valid;
  assign quad.left        = sat32(51'(s3_pk) + 51'(s3_px));
  assign quad.right       = sat32(51'(s3_pk) + 51'(s3_dxr));
  assign quad.top         = sat32(51'(s3_py0) - 51'(s3_py));
  assign quad.bottom      = sat32(51'(s3_py0) - 51'(s3_dyb));
  assign quad.u0          = s3_u0;
  assign quad.v0          = s3_v0;
  assign quad.u1          = s3_u1;
  assign quad.v1          = s3_v1;
  assign quad.quad_number = s3_qn;

  // a start loads the pen origin
  `GQLK_ASSERT(a_start_loads_pen, s2_valid && s2_start |=> (pen_x == $past(s2_xv)) && (pen_y == $past(s2_yv)), "start did not load pen")

endmodule
`default_nettype wire

FILE: rtl/gqlk_outq.sv
// Output queue with slot reservation made at accept time.
`default_nettype none
`include "glyph_quad_layout_kerning_top_assert.svh"
module gqlk_outq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            reserve,
  input  wire logic            push,
  input  wire gqlk_pkg::quad_t quad_in,
  input  wire logic            out_stall,
  output logic                 out_valid,
  output gqlk_pkg::quad_t      quad_out,
  output logic                 full
);
  import gqlk_pkg::*;

  localparam int PW   = $clog2(OUT_DEPTH);
  localparam int CNTW = $clog2(OUT_DEPTH + 1);

  quad_t           q_mem [OUT_DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;   // words held
  logic [CNTW-1:0] credit;  // words held or still in the pipe
  logic            pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign quad_out  = q_mem[rd_ptr];
  assign full      = (credit == CNTW'(OUT_DEPTH));

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= quad_in;
    end
  end

  // pointers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      credit <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count  <= count + CNTW'(push) - CNTW'(pop);
      credit <= credit + CNTW'(reserve) - CNTW'(pop);
    end
  end

  // every held word had a slot reserved for it
  `GQLK_ASSERT(a_count_within_credit, count <= credit, "queue holds more than reserved")
  // reservation keeps the queue from overflowing
  `GQLK_ASSERT(a_push_has_room, push |-> (count != CNTW'(OUT_DEPTH)), "push into full queue")

endmodule
`default_nettype wire

FILE: rtl/glyph_quad_layout_kerning_top.sv
// Top level of the bitmap-font text layout engine with pair kerning.
//
// Input channel (in_valid / in_stall) carries one command word: start a
// string, lay out a character, load a glyph entry or load a kerning byte.
// Output channel (out_valid / out_stall) carries one quad word per accepted
// character that passes the range and loaded checks; other words give none.
// Configuration registers sit on the APB-style port; the user must write
// them only while idle, and the block itself does not enforce this.
// Throughput: one input word per clock while in_stall is low. The glyph and
// kerning tables are single-port memories with one access per word, and the
// pen register loop (kerning add, advance add) closes in one stage of the
// math pipe. A quad word passes the front-end registers, the stage 2 and
// stage 3 registers and the output queue before out_valid presents it.
// An eight-word output queue decouples the sides: a slot is reserved when a
// character is accepted, and in_stall rises only when all eight slots are
// reserved, so a stalled receiver backs up the input after eight quads.
// Reset clears the glyph and kerning-row valid bits, the pen, the string
// state and the queue; there is no clearing pass.
`default_nettype none
module glyph_quad_layout_kerning_top #(
  parameter int GLYPH_ENTRIES = gqlk_pkg::GLYPH_ENTRIES_DEF,
  parameter int KERN_ROWS     = gqlk_pkg::KERN_ROWS_DEF,
  parameter int KERN_COLS     = gqlk_pkg::KERN_COLS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // config port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gqlk_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    command,
  input  wire logic [15:0]                   code,
  input  wire logic [15:0]                   column,
  input  wire logic signed [31:0]            x_value,
  input  wire logic signed [31:0]            y_value,
  input  wire logic [9:0]                    box_width,
  input  wire logic [9:0]                    box_height,
  input  wire logic signed [10:0]            advance,
  input  wire logic [15:0]                   tex_u0,
  input  wire logic [15:0]                   tex_v0,
  input  wire logic [15:0]                   tex_u1,
  input  wire logic [15:0]                   tex_v1,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [31:0]                 quad_left,
  output logic signed [31:0]                 quad_right,
  output logic signed [31:0]                 quad_top,
  output logic signed [31:0]                 quad_bottom,
  output logic [15:0]                        out_u0,
  output logic [15:0]                        out_v0,
  output logic [15:0]                        out_u1,
  output logic [15:0]                        out_v1,
  output logic [13:0]                        quad_number
);
  import gqlk_pkg::*;

  cfg_t               cfg;
  front_word_t        s1;
  glyph_rec_t         glyph;
  logic signed [7:0]  kern;
  logic               reserve;
  logic               push;
  quad_t              quad_new, quad_head;
  logic               in_acc;
  logic               full;

  assign in_stall = full;
  assign in_acc   = in_valid && !in_stall;

  gqlk_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gqlk_front #(
    .GLYPH_ENTRIES (GLYPH_ENTRIES),
    .KERN_ROWS     (KERN_ROWS),
    .KERN_COLS     (KERN_COLS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_acc     (in_acc),
    .command    (command),
    .code       (code),
    .column     (column),
    .x_value    (x_value),
    .y_value    (y_value),
    .box_width  (box_width),
    .box_height (box_height),
    .advance    (advance),
    .tex_u0     (tex_u0),
    .tex_v0     (tex_v0),
    .tex_u1     (tex_u1),
    .tex_v1     (tex_v1),
    .cfg        (cfg),
    .s1         (s1),
    .glyph      (glyph),
    .kern       (kern),
    .reserve    (reserve)
  );

  gqlk_math u_math (
    .clk   (clk),
    .rst   (rst),
    .scale (cfg.scale),
    .s1    (s1),
    .glyph (glyph),
    .kern  (kern),
    .push  (push),
    .quad  (quad_new)
  );

  gqlk_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .reserve   (reserve),
    .push      (push),
    .quad_in   (quad_new),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .quad_out  (quad_head),
    .full      (full)
  );

  assign quad_left   = quad_head.left;
  assign quad_right  = quad_head.right;
  assign quad_top    = quad_head.top;
  assign quad_bottom = quad_head.bottom;
  assign out_u0      = quad_head.u0;
  assign out_v0      = quad_head.v0;
  assign out_u1      = quad_head.u1;
  assign out_v1      = quad_head.v1;
  assign quad_number = quad_head.quad_number;

endmodule
`default_nettype wire
